// ===== src/ms_pkg.sv =====
// Package for the merge sorter: shared types.
// No dependencies; imported by the top level.
package ms_pkg;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_RUN,
        S_READ,
        S_MERGE,
        S_EMIT_RD,
        S_EMIT_OUT
    } ms_state_t;

endpackage

// ===== src/ms_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== src/merge_sorter.sv =====
// Merge sorter top level: load, bottom-up merge passes and emit sequencer.
// Depends on ms_pkg and ms_ram (two instances used as ping-pong stores).
//
// Usage: values enter on the s_ channel one item per cycle while s_tready is
// high; s_tlast marks the final value of a set and starts the sort. Values
// beyond MAX_ITEMS are dropped and every result of that set carries tuser=1.
// While sorting and emitting, s_tready is low. A single signed comparator is
// shared by all merge steps: each result element of a pass is a RAM read,
// then a compare and write; each run pair adds a setup state (S_RUN) and
// each pass a check state (S_PASS) and a closing S_RUN. A set of n values
// needs ceil(log2 n) passes. Results leave on the m_ channel in ascending
// order, each item read from the store (S_EMIT_RD) before it is offered
// (S_EMIT_OUT), with m_tlast on the final one. If m_tready is low the
// current item is held until taken; only then is the next one read. Reset
// empties the set; the stores are not cleared and need no clearing pass.
module merge_sorter
    import ms_pkg::*;
#(
    parameter int MAX_ITEMS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,   // value_in
    input  logic                                s_tlast,   // last_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]     m_tdata,   // value_out
    output logic                                m_tlast,   // last_out
    output logic                                m_tuser    // overflow
);

    localparam int DB = ((VALUE_BITS + 7) / 8) * 8;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = CW + 2;

    ms_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic          src_reg, src_next;
    logic [PW-1:0] rw_reg, rw_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;

    logic [PW-1:0]         n_ext, mid_sum, hi_sum;
    logic                  we0, we1;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr_a, rd_addr_b;
    logic [VALUE_BITS-1:0] rd0_a, rd0_b, rd1_a, rd1_b, val_a, val_b;
    logic                  take_left;
    logic [CW-1:0]         k_inc;

    ms_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_ram0 (
        .clk       (clk),
        .we        (we0),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd0_a),
        .rd_data_b (rd0_b)
    );

    ms_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_ram1 (
        .clk       (clk),
        .we        (we1),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd1_a),
        .rd_data_b (rd1_b)
    );

    assign val_a   = src_reg ? rd1_a : rd0_a;
    assign val_b   = src_reg ? rd1_b : rd0_b;
    assign n_ext   = PW'(count_reg);
    assign mid_sum = lo_reg + rw_reg;
    assign hi_sum  = lo_reg + (rw_reg << 1);
    assign k_inc   = k_reg + CW'(1);

    // Ties take the left run, which keeps equal values in input order.
    assign take_left = (i_reg < mid_reg)
                    && ((j_reg >= hi_reg) || ($signed(val_a) <= $signed(val_b)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            src_reg   <= 1'b0;
            rw_reg    <= PW'(1);
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            src_reg   <= src_next;
            rw_reg    <= rw_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        src_next   = src_reg;
        rw_next    = rw_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;

        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        we0       = 1'b0;
        we1       = 1'b0;
        wr_addr   = k_reg[AW-1:0];
        wr_data   = take_left ? val_a : val_b;
        rd_addr_a = i_reg[AW-1:0];
        rd_addr_b = j_reg[AW-1:0];

        case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                wr_addr  = count_reg[AW-1:0];
                wr_data  = s_tdata[VALUE_BITS-1:0];
                if (s_tvalid)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        we0        = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        src_next   = 1'b0;
                        rw_next    = PW'(1);
                        state_next = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                if (rw_reg >= n_ext)
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (lo_reg >= n_ext)
                begin
                    src_next   = ~src_reg;
                    rw_next    = rw_reg << 1;
                    state_next = S_PASS;
                end
                else
                begin
                    mid_next   = (mid_sum > n_ext) ? count_reg : mid_sum[CW-1:0];
                    hi_next    = (hi_sum > n_ext) ? count_reg : hi_sum[CW-1:0];
                    i_next     = lo_reg[CW-1:0];
                    j_next     = (mid_sum > n_ext) ? count_reg : mid_sum[CW-1:0];
                    k_next     = lo_reg[CW-1:0];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                we0 = src_reg;
                we1 = ~src_reg;
                if (take_left)
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    lo_next    = PW'(hi_reg);
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_EMIT_RD:
            begin
                rd_addr_a  = k_reg[AW-1:0];
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                rd_addr_a = k_reg[AW-1:0];
                m_tvalid  = 1'b1;
                if (m_tready)
                begin
                    if (k_inc == count_reg)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign m_tdata = DB'(val_a);
    assign m_tlast = (k_inc == count_reg);
    assign m_tuser = drop_reg;

endmodule
